FILE: hw/rtl/pbs_pkg.sv
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared types, codes and helpers for the platformer body step unit.
// ----------------------------------------------------------------------------
package pbs_pkg;

  localparam int MAX_PLAT   = 32;
  localparam int PLAT_AW    = 5;
  localparam int CW         = 25;   // coordinate width, signed Q16.8
  localparam int SW         = 24;   // size width, unsigned Q16.8
  localparam int CNT_W      = 6;
  localparam int NUM_W      = 41;   // divider dividend width
  localparam int DEN_W      = 20;   // divider divisor width
  localparam int WIDE_W     = 28;   // working width for edge arithmetic
  localparam int RECIP_SH   = 27;   // shift after the reciprocal multiply

  // func codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_VEL   = 2'd1;
  localparam logic [1:0] FUNC_MOVE  = 2'd2;

  // config register indexes
  localparam logic CFG_PLAT_COUNT = 1'b0;
  localparam logic CFG_GRAVITY    = 1'b1;

  localparam logic [19:0] GRAVITY_RST = 20'd256000;
  localparam logic signed [WIDE_W-1:0] EPS_Q    = 28'sd128;
  localparam logic signed [25:0]       VY_LIMIT = 26'sd204800;
  localparam logic [DEN_W-1:0]         DAMP_ONE = 20'd65536;
  // ceil(2^27 / 5): exact floor(n / 5) for every n below 2^26
  localparam logic [CW-1:0]            RECIP5   = 25'd26843546;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [SW-1:0]        dim_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    dim_t   wide;
    dim_t   tall;
  } plat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_V_START,
    ST_V_DIV,
    ST_M_MULX,
    ST_M_MULY,
    ST_M_POSY,
    ST_X_RD,
    ST_X_EV,
    ST_X_REFL,
    ST_Y_RD,
    ST_Y_EV,
    ST_Y_REFL,
    ST_G_RD,
    ST_G_EV,
    ST_FIN
  } state_t;

  function automatic logic signed [WIDE_W-1:0] ext_c(input coord_t v);
    ext_c = {{(WIDE_W-CW){v[CW-1]}}, v};
  endfunction

  function automatic logic signed [WIDE_W-1:0] ext_d(input dim_t v);
    ext_d = {{(WIDE_W-SW){1'b0}}, v};
  endfunction

  function automatic coord_t sat_coord(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = 28'sd16777215;
    lo = -28'sd16777216;
    if (v > hi)      sat_coord = coord_t'(hi[CW-1:0]);
    else if (v < lo) sat_coord = coord_t'(lo[CW-1:0]);
    else             sat_coord = coord_t'(v[CW-1:0]);
  endfunction

  function automatic logic [CW-1:0] mag_c(input coord_t v);
    mag_c = v[CW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

FILE: hw/rtl/platformer_body_step_unit.sv
// ----------------------------------------------------------------------------
// platformer_body_step_unit
// Steps one platformer body: velocity update, or move with AABB push-out
// against a table of platform rectangles, using one shared multiplier, a
// reflection reciprocal multiplier and one serial divider under a sequencer.
// ----------------------------------------------------------------------------
// Func 0 (table write) and func 3 give no result.
// Func 1: velocity update using the serial damping divide.
// Func 2: setup states MULX, MULY and POSY, up to three table passes (x, y,
//   ground probe), a finish state, plus a reflection state per push-out.
// One word in flight; next word accepted the cycle after the result is loaded.
// Synchronous active-low reset clears control state, presets config registers.
module platformer_body_step_unit import pbs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: slot, pos_x, pos_y, size_w, size_h, vel_x, vel_y, on_ground, dt
  input  logic [175:0] in_tdata,
  input  logic [1:0]   in_tuser,  // func
  input  logic         in_tvalid,
  output logic         in_tready,
  // out_tdata: out_x, out_y, out_vel_x, out_vel_y, out_on_ground
  output logic [103:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_wr_en,
  input  logic         cfg_addr,
  input  logic [19:0]  cfg_wdata
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] pc_r;
  logic [19:0]      grav_r;

  coord_t px_r, py_r, vx_r, vy_r, old_x_r, old_y_r;
  dim_t   w_r, h_r;
  logic [15:0] dt_r;
  logic   gnd_r, landed_r;
  logic [CNT_W-1:0] idx_r, lim_r;
  logic signed [42:0] prod_r;
  logic [103:0] out_data_r;
  logic         out_valid_r;
  logic [CW-1:0] refl_q_r;

  // input word fields
  logic [PLAT_AW-1:0] in_slot;
  plat_t              in_plat;
  logic               in_acc;
  assign in_slot = in_tdata[4:0];
  assign in_plat = '{left: in_tdata[29:5], top: in_tdata[54:30],
                     wide: in_tdata[78:55], tall: in_tdata[102:79]};
  assign in_acc  = in_tvalid && in_tready;

  // platform table
  plat_t rd;
  pbs_table u_table (
    .clk   (clk),
    .we    (in_acc && (in_tuser == FUNC_WRITE)),
    .waddr (in_slot),
    .wdata (in_plat),
    .raddr (idx_r[PLAT_AW-1:0]),
    .rdata (rd)
  );

  // serial divider, damping only
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [CW-1:0]    div_q;
  pbs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // shared multiplier
  logic signed [25:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [42:0] mul_p;
  always_comb begin
    case (state_r)
      ST_V_START: mul_a = $signed({6'b0, grav_r});
      ST_M_MULY:  mul_a = {vy_r[CW-1], vy_r};
      default:    mul_a = {vx_r[CW-1], vx_r};
    endcase
  end
  assign mul_b = $signed({1'b0, dt_r});
  assign mul_p = mul_a * mul_b;

  // edge arithmetic against the current table entry
  logic signed [WIDE_W-1:0] pl, pr, pt, pb, bx, bxr, oy, oyb, ny, nyb, ox, dd;
  logic ov_x, ov_y, c_land, c_head, g_hit;
  assign pl  = ext_c(rd.left);
  assign pr  = pl + ext_d(rd.wide);
  assign pt  = ext_c(rd.top);
  assign pb  = pt + ext_d(rd.tall);
  assign bx  = ext_c(px_r);
  assign bxr = bx + ext_d(w_r);
  assign ox  = ext_c(old_x_r);
  assign oy  = ext_c(old_y_r);
  assign oyb = oy + ext_d(h_r);
  assign ny  = ext_c(py_r);
  assign nyb = ny + ext_d(h_r);
  assign dd  = pt - nyb;
  assign ov_x   = (bx < pr) && (bxr > pl) && (oy < pb) && (oyb > pt);
  assign ov_y   = (bx < pr) && (bxr > pl) && (ny < pb) && (nyb > pt);
  assign c_land = (oyb <= pt + EPS_Q) && !vy_r[CW-1];
  assign c_head = (oy >= pb - EPS_Q) && vy_r[CW-1];
  assign g_hit  = (bxr > pl) && (bx < pr) && (dd > -EPS_Q) && (dd < EPS_Q);

  // motion terms
  logic signed [WIDE_W-1:0] step_v;
  logic signed [25:0]       vy_sum;
  logic [DEN_W-1:0]         damp_den;
  logic                     idx_in;
  coord_t                   q_pos, q_neg;
  assign step_v   = {prod_r[42], prod_r[42:16]};
  assign vy_sum   = {vy_r[CW-1], vy_r} +
                    (gnd_r ? 26'sd0 : $signed({6'b0, prod_r[35:16]}));
  assign damp_den = DAMP_ONE + {1'b0, dt_r, 3'b0} + {3'b0, dt_r, 1'b0};
  assign idx_in   = idx_r < lim_r;
  assign q_pos    = coord_t'(div_q);
  assign q_neg    = coord_t'(-div_q);

  assign div_start = (state_r == ST_V_START);
  assign div_num   = {mag_c(vx_r), 16'b0};
  assign div_den   = damp_den;

  // reflect magnitude: |v| / 5 by reciprocal multiply, registered
  logic [CW-1:0]   refl_src;
  logic [2*CW-1:0] refl_p;
  assign refl_src = (state_r == ST_Y_EV) ? mag_c(vy_r) : mag_c(vx_r);
  assign refl_p   = {{CW{1'b0}}, refl_src} * {{CW{1'b0}}, RECIP5};

  always_ff @(posedge clk) begin
    refl_q_r <= CW'(refl_p[2*CW-1:RECIP_SH]);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    in_tready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            FUNC_VEL:  state_nxt = ST_V_START;
            FUNC_MOVE: state_nxt = ST_M_MULX;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_V_START: state_nxt = ST_V_DIV;
      ST_V_DIV:  if (div_done) state_nxt = ST_FIN;
      ST_M_MULX: state_nxt = ST_M_MULY;
      ST_M_MULY: state_nxt = ST_M_POSY;
      ST_M_POSY: state_nxt = ST_X_RD;
      ST_X_RD:   state_nxt = idx_in ? ST_X_EV : ST_Y_RD;
      ST_X_EV:   state_nxt = ov_x ? ST_X_REFL : ST_X_RD;
      ST_X_REFL: state_nxt = ST_X_RD;
      ST_Y_RD: begin
        if (idx_in)        state_nxt = ST_Y_EV;
        else if (landed_r) state_nxt = ST_FIN;
        else               state_nxt = ST_G_RD;
      end
      ST_Y_EV:   state_nxt = (ov_y && (c_land || c_head)) ? ST_Y_REFL : ST_Y_RD;
      ST_Y_REFL: state_nxt = ST_Y_RD;
      ST_G_RD:   state_nxt = idx_in ? ST_G_EV : ST_FIN;
      ST_G_EV:   state_nxt = g_hit ? ST_FIN : ST_G_RD;
      ST_FIN:    if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      grav_r <= GRAVITY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_PLAT_COUNT: pc_r   <= cfg_wdata[CNT_W-1:0];
        CFG_GRAVITY:    grav_r <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // body datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        px_r     <= in_tdata[29:5];
        py_r     <= in_tdata[54:30];
        old_x_r  <= in_tdata[29:5];
        old_y_r  <= in_tdata[54:30];
        w_r      <= in_tdata[78:55];
        h_r      <= in_tdata[102:79];
        vx_r     <= in_tdata[127:103];
        vy_r     <= in_tdata[152:128];
        gnd_r    <= in_tdata[153];
        dt_r     <= in_tdata[169:154];
        landed_r <= 1'b0;
        idx_r    <= '0;
        lim_r    <= (pc_r > CNT_W'(MAX_PLAT)) ? CNT_W'(MAX_PLAT) : pc_r;
      end
      ST_V_START: prod_r <= mul_p;
      ST_V_DIV: begin
        if (div_done) begin
          vx_r <= vx_r[CW-1] ? q_neg : q_pos;
          if (vy_sum > VY_LIMIT)       vy_r <= coord_t'(VY_LIMIT[CW-1:0]);
          else if (vy_sum < -VY_LIMIT) vy_r <= coord_t'(-VY_LIMIT);
          else                         vy_r <= vy_sum[CW-1:0];
        end
      end
      ST_M_MULX: prod_r <= mul_p;
      ST_M_MULY: begin
        px_r   <= sat_coord(ext_c(px_r) + step_v);
        prod_r <= mul_p;
      end
      ST_M_POSY: py_r <= sat_coord(ext_c(py_r) + step_v);
      ST_X_RD:   if (!idx_in) idx_r <= '0;
      ST_X_EV: begin
        if (ov_x) begin
          if (ox + ext_d(w_r) <= pl) px_r <= sat_coord(pl - ext_d(w_r));
          else if (ox >= pr)         px_r <= sat_coord(pr);
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      ST_X_REFL: begin
        vx_r  <= vx_r[CW-1] ? coord_t'(refl_q_r) : coord_t'(-refl_q_r);
        idx_r <= idx_r + 1'b1;
      end
      ST_Y_RD: begin
        if (!idx_in) begin
          idx_r <= '0;
          gnd_r <= landed_r;
        end
      end
      ST_Y_EV: begin
        if (ov_y && c_land) begin
          py_r     <= sat_coord(pt - ext_d(h_r));
          landed_r <= 1'b1;
        end else if (ov_y && c_head) begin
          py_r <= sat_coord(pb);
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      ST_Y_REFL: begin
        vy_r  <= vy_r[CW-1] ? coord_t'(refl_q_r) : coord_t'(-refl_q_r);
        idx_r <= idx_r + 1'b1;
      end
      ST_G_EV: begin
        if (g_hit) gnd_r <= 1'b1;
        else       idx_r <= idx_r + 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && (!out_valid_r || out_tready))
      out_data_r <= {3'b0, gnd_r, vy_r, vx_r, py_r, px_r};
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

  // checks
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_V_DIV))
    else $error("divider finished outside a wait state");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (idx_r <= lim_r))
    else $error("table index ran past platform count");

  a_vy_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_V_DIV && div_done) |=>
      ($signed(vy_r) <= 25'sd204800 && $signed(vy_r) >= -25'sd204800))
    else $error("vertical velocity outside clamp");

  a_landed_ground: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && landed_r) |-> gnd_r)
    else $error("landing did not set grounded flag");

endmodule

FILE: hw/rtl/pbs_div.sv
// ----------------------------------------------------------------------------
// pbs_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbs_div import pbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [CW-1:0]    quot
);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             ge;

  // trial subtract of the divisor
  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, den_r};
  assign ge     = !diff[DEN_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r[CW-1:0];

endmodule

FILE: hw/rtl/pbs_table.sv
// ----------------------------------------------------------------------------
// pbs_table
// Platform rectangle table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pbs_table import pbs_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [PLAT_AW-1:0] waddr,
  input  plat_t              wdata,
  input  logic [PLAT_AW-1:0] raddr,
  output plat_t              rdata
);

  plat_t mem [MAX_PLAT];
  plat_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
